### src/cap_sense_charge_timer_core_assert.svh
// ----------------------------------------------------------------------------
// Charge timer assertion macros
// Clocked, reset-qualified property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef CAP_SENSE_CHARGE_TIMER_CORE_ASSERT_SVH
`define CAP_SENSE_CHARGE_TIMER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("charge timer check failed in same cycle");

// Consequent must hold in the cycle after the antecedent.
`define CST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("charge timer check failed in next cycle");

`endif

### src/cst_pkg.sv
// ----------------------------------------------------------------------------
// Charge timer package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

    // Sample ring depth and derived widths
    localparam int MAX_SAMPLES = 16;
    localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Field widths
    localparam int TICK_W    = 16;
    localparam int ELAPSED_W = 17;
    localparam int SUM_W     = 21;
    localparam int SCNT_W    = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

    localparam logic [TICK_W-1:0] TIMEOUT_RST      = 16'd1000;
    localparam logic [TICK_W-1:0] DISCHARGE_RST    = 16'd1000;
    localparam logic [SCNT_W-1:0] SAMPLE_COUNT_RST = 5'd16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // Measurement phase; the unused code behaves as start
    typedef enum logic [1:0] {
        PH_START     = 2'd0,
        PH_CHARGE    = 2'd1,
        PH_DISCHARGE = 2'd2
    } t_phase;

    // Ring write request from the sequencer
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic [ELAPSED_W-1:0] data;
    } t_ring_wr;

endpackage

`default_nettype wire

### src/cst_in_if.sv
// ----------------------------------------------------------------------------
// Charge timer input channel
// One item per tick carrying the receive edge flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_in_if;
    logic valid;
    logic ready;
    logic edge_seen;

    modport source (output valid, output edge_seen, input ready);
    modport sink   (input valid, input edge_seen, output ready);
endinterface

`default_nettype wire

### src/cst_out_if.sv
// ----------------------------------------------------------------------------
// Charge timer output channel
// One item per tick: drive level, sample and cumulative charge time.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_out_if
    import cst_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic                 drive_level;
    logic                 sample_valid;
    logic [ELAPSED_W-1:0] sample_ticks;
    logic [SUM_W-1:0]     charge_sum;

    modport source (output valid, output drive_level, output sample_valid,
                    output sample_ticks, output charge_sum, input ready);
    modport sink   (input valid, input drive_level, input sample_valid,
                    input sample_ticks, input charge_sum, output ready);
endinterface

`default_nettype wire

### src/cst_ring.sv
// ----------------------------------------------------------------------------
// Charge timer sample ring
// Holds the last charge times and a prefix sum per entry, so the sum over
// any number of entries in use is one lookup plus the pending update.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_ring
    import cst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ring_wr         i_wr,
    input  logic [CNT_W-1:0] i_used,
    output logic [SUM_W-1:0] o_sum
);

    logic [ELAPSED_W-1:0] r_ring   [MAX_SAMPLES];
    logic [SUM_W-1:0]     r_prefix [MAX_SAMPLES];
    logic [SUM_W-1:0]     delta;
    logic [IDX_W-1:0]     last_idx;
    logic                 in_use;

    // Change of the written entry, modulo the sum width
    assign delta    = SUM_W'(i_wr.data) - SUM_W'(r_ring[i_wr.idx]);
    assign last_idx = IDX_W'(i_used - 1'b1);
    assign in_use   = i_wr.en && (CNT_W'(i_wr.idx) < i_used);

    // Sum over the entries in use, after this tick's write
    assign o_sum = r_prefix[last_idx] + (in_use ? delta : '0);

    // Store the sample and shift every prefix sum that covers it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SAMPLES; k++) begin
                r_ring[k]   <= '0;
                r_prefix[k] <= '0;
            end
        end else if (i_wr.en) begin
            r_ring[i_wr.idx] <= i_wr.data;
            for (int k = 0; k < MAX_SAMPLES; k++) begin
                if (IDX_W'(k) >= i_wr.idx) begin
                    r_prefix[k] <= r_prefix[k] + delta;
                end
            end
        end
    end

endmodule

`default_nettype wire

### src/cap_sense_charge_timer_core.sv
// ----------------------------------------------------------------------------
// Capacitive touch charge timer
// Start / charge / discharge sequencer with a ring of charge times.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per microsecond tick with the receive edge flag.
//   o_out returns exactly one item per input item: the electrode drive level
//   after the tick, a sample flag with the measured charge time, and the sum
//   of the ring entries in use.
//   Output valid rises in the cycle after input acceptance. Throughput is
//   one item per cycle while the receiver takes items: the next input item
//   is taken in the same cycle the single output register stage is emptied.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; index 0
//   is the timeout, 1 the discharge delay, 2 the sample count.
//   Reset clears the ring, the sums and the sequencer (start phase, drive
//   low) and loads the register defaults; no clearing pass is needed.
//   When the receiver stalls, the output item holds and i_in.ready drops
//   until it is taken; no item is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module cap_sense_charge_timer_core
    import cst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cst_in_if.sink                i_in,
    cst_out_if.source             o_out
);

    // Configuration registers
    logic [TICK_W-1:0] r_timeout;
    logic [TICK_W-1:0] r_discharge;
    logic [SCNT_W-1:0] r_sample_count;

    // Sequencer state
    t_phase               r_phase, n_phase;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [IDX_W-1:0]     r_widx, n_widx;
    logic                 r_drive, n_drive;

    // Output register
    logic                 r_out_valid;
    logic                 r_out_drive;
    logic                 r_out_sample_valid;
    logic [ELAPSED_W-1:0] r_out_sample_ticks;
    logic [SUM_W-1:0]     r_out_sum;

    logic                 in_fire;
    logic [CNT_W-1:0]     used;
    logic [IDX_W-1:0]     widx_eff;
    logic [CNT_W-1:0]     widx_inc;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 store;
    t_ring_wr             ring_wr;
    logic [SUM_W-1:0]     sum_next;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    // Clamp the sample count to the ring depth; a zero count acts as one
    always_comb begin
        if (r_sample_count == '0) begin
            used = CNT_W'(1);
        end else if (CNT_W'(r_sample_count) > CNT_W'(MAX_SAMPLES)) begin
            used = CNT_W'(MAX_SAMPLES);
        end else begin
            used = CNT_W'(r_sample_count);
        end
    end

    // Write pointer wraps before and after a store
    assign widx_eff    = (CNT_W'(r_widx) >= used) ? '0 : r_widx;
    assign widx_inc    = CNT_W'(widx_eff) + 1'b1;
    assign elapsed_inc = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;

    // Next phase, counter and drive level
    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_widx    = r_widx;
        n_drive   = r_drive;
        store     = 1'b0;
        unique case (r_phase)
            PH_CHARGE: begin
                if (i_in.edge_seen && (r_elapsed != '0)) begin
                    store     = 1'b1;
                    n_widx    = (widx_inc >= used) ? '0 : IDX_W'(widx_inc);
                    n_drive   = 1'b0;
                    n_elapsed = '0;
                    n_phase   = PH_DISCHARGE;
                end else if (r_elapsed > ELAPSED_W'(r_timeout)) begin
                    n_drive   = 1'b0;
                    n_elapsed = '0;
                    n_phase   = PH_DISCHARGE;
                end else begin
                    n_elapsed = elapsed_inc;
                end
            end
            PH_DISCHARGE: begin
                if (r_elapsed > ELAPSED_W'(r_discharge)) begin
                    n_phase = PH_START;
                end else begin
                    n_elapsed = elapsed_inc;
                end
            end
            default: begin
                n_drive   = 1'b1;
                n_elapsed = '0;
                n_phase   = PH_CHARGE;
            end
        endcase
    end

    assign ring_wr.en   = in_fire && store;
    assign ring_wr.idx  = widx_eff;
    assign ring_wr.data = r_elapsed;

    cst_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (ring_wr),
        .i_used  (used),
        .o_sum   (sum_next)
    );

    // Load configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout      <= TIMEOUT_RST;
            r_discharge    <= DISCHARGE_RST;
            r_sample_count <= SAMPLE_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT:      r_timeout      <= i_cfg_data;
                CFG_DISCHARGE:    r_discharge    <= i_cfg_data;
                CFG_SAMPLE_COUNT: r_sample_count <= SCNT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Advance the sequencer once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_elapsed <= '0;
            r_widx    <= '0;
            r_drive   <= 1'b0;
        end else if (in_fire) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_widx    <= n_widx;
            r_drive   <= n_drive;
        end
    end

    // Hold the result item until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_drive        <= n_drive;
            r_out_sample_valid <= store;
            r_out_sample_ticks <= store ? r_elapsed : '0;
            r_out_sum          <= sum_next;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.drive_level  = r_out_drive;
    assign o_out.sample_valid = r_out_sample_valid;
    assign o_out.sample_ticks = r_out_sample_ticks;
    assign o_out.charge_sum   = r_out_sum;

endmodule

`default_nettype wire

### src/cst_checker.sv
// ----------------------------------------------------------------------------
// Charge timer port checker
// Watches the top-level channels over time and flags broken results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cap_sense_charge_timer_core_assert.svh"

module cst_checker
    import cst_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic                 i_out_drive_level,
    input logic                 i_out_sample_valid,
    input logic [ELAPSED_W-1:0] i_out_sample_ticks,
    input logic [SUM_W-1:0]     i_out_charge_sum
);

    // A stalled result item keeps its content
    `CST_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_sample_ticks) && $stable(i_out_charge_sum))

    // Every accepted input item produces a result item next cycle
    `CST_ASSERT_NEXT(a_in_to_out, i_in_valid && i_in_ready, i_out_valid)

    // A stored sample is nonzero and comes with the electrode released
    `CST_ASSERT_SAME(a_sample_ok, i_out_valid && i_out_sample_valid, !i_out_drive_level && (i_out_sample_ticks != '0))

    // No sample flag means no charge time
    `CST_ASSERT_SAME(a_no_sample, i_out_valid && !i_out_sample_valid, i_out_sample_ticks == '0)

endmodule

bind cap_sense_charge_timer_core cst_checker u_cst_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_drive_level  (o_out.drive_level),
    .i_out_sample_valid (o_out.sample_valid),
    .i_out_sample_ticks (o_out.sample_ticks),
    .i_out_charge_sum   (o_out.charge_sum)
);

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Charge timer testbench
// Feeds tick items with random receive edges through the valid/ready input
// channel, predicts every output item from a cycle model of the start, charge
// and discharge sequencer and its ring of charge times, and checks each
// output item field by field. Registers are rewritten between segments while
// the block is idle; idling, a long receiver hold-off and sender pauses shake
// the handshakes.
// ----------------------------------------------------------------------------

module testbench;
    import cst_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SEGMENTS    = 24;
    localparam int SEG_ITEMS   = 48;

    typedef enum {JOB_ITEM, JOB_CFG, JOB_DRAIN, JOB_MODE, JOB_HOLD} t_job_kind;

    typedef struct {
        t_job_kind             kind;
        logic                  edge_flag;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        int                    arg_a;
        int                    arg_b;
    } t_job;

    typedef struct packed {
        logic                 drive_level;
        logic                 sample_valid;
        logic [ELAPSED_W-1:0] sample_ticks;
        logic [SUM_W-1:0]     charge_sum;
    } t_tick_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cst_in_if  in_ch ();
    cst_out_if out_ch ();

    cap_sense_charge_timer_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Stimulus and expectations
    t_job         stim_q[$];
    t_tick_result pending_results[$];

    // Handshake shaping
    int tx_idle_pct = 31;
    int rx_idle_pct = 62;
    int hold_token  = 0;
    int hold_taken  = 0;
    int hold_len    = 0;
    int hold_left   = 0;

    // Bookkeeping
    int err_cnt      = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int samples_seen = 0;
    int cfg_writes   = 0;
    int stall_cycles = 0;

    // Timer model state, at its reset values
    t_phase               ph          = PH_START;
    logic [ELAPSED_W-1:0] el_cnt      = '0;
    int                   wr_ptr      = 0;
    logic [ELAPSED_W-1:0] charge_ring [MAX_SAMPLES] = '{default: '0};
    logic                 drive_now   = 1'b0;
    logic [TICK_W-1:0]    cfg_timeout   = TIMEOUT_RST;
    logic [TICK_W-1:0]    cfg_discharge = DISCHARGE_RST;
    logic [SCNT_W-1:0]    cfg_count     = SAMPLE_COUNT_RST;

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Advance the timer model by one tick and return the output item it makes
    function automatic t_tick_result advance_timer(logic edge_in);
        t_tick_result     res;
        int               n;
        int               i;
        logic [SUM_W-1:0] acc;
        res = '0;
        n = (cfg_count == 0) ? 1 :
            ((cfg_count > MAX_SAMPLES) ? MAX_SAMPLES : int'(cfg_count));
        case (ph)
            PH_CHARGE: begin
                if (edge_in && el_cnt >= 1) begin
                    if (wr_ptr >= n) wr_ptr = 0;
                    charge_ring[wr_ptr] = el_cnt;
                    res.sample_valid = 1'b1;
                    res.sample_ticks = el_cnt;
                    wr_ptr++;
                    if (wr_ptr >= n) wr_ptr = 0;
                    drive_now = 1'b0;
                    el_cnt = '0;
                    ph = PH_DISCHARGE;
                end else if (el_cnt > cfg_timeout) begin
                    drive_now = 1'b0;
                    el_cnt = '0;
                    ph = PH_DISCHARGE;
                end else if (el_cnt != ELAPSED_MAX) begin
                    el_cnt++;
                end
            end
            PH_DISCHARGE: begin
                if (el_cnt > cfg_discharge) ph = PH_START;
                else if (el_cnt != ELAPSED_MAX) el_cnt++;
            end
            default: begin
                drive_now = 1'b1;
                el_cnt = '0;
                ph = PH_CHARGE;
            end
        endcase
        acc = '0;
        for (i = 0; i < n; i++) acc += SUM_W'(charge_ring[i]);
        res.drive_level = drive_now;
        res.charge_sum  = acc;
        return res;
    endfunction

    // Mirror a register write into the model
    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TIMEOUT:      cfg_timeout   = data[TICK_W-1:0];
            CFG_DISCHARGE:    cfg_discharge = data[TICK_W-1:0];
            CFG_SAMPLE_COUNT: cfg_count     = data[SCNT_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    // Queue helpers
    task automatic push_item(logic edge_flag);
        t_job job;
        job = '{kind: JOB_ITEM, edge_flag: edge_flag, reg_idx: '0, reg_data: '0,
                arg_a: 0, arg_b: 0};
        stim_q.push_back(job);
    endtask

    task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_job job;
        job = '{kind: JOB_CFG, edge_flag: 1'b0, reg_idx: idx, reg_data: data,
                arg_a: 0, arg_b: 0};
        stim_q.push_back(job);
    endtask

    task automatic push_ctrl(t_job_kind kind, int a, int b);
        t_job job;
        job = '{kind: kind, edge_flag: 1'b0, reg_idx: '0, reg_data: '0,
                arg_a: a, arg_b: b};
        stim_q.push_back(job);
    endtask

    // Drive input items and register writes from the job queue
    always @(posedge i_clk) begin : drive_items
        t_job                  job;
        logic                  nv;
        logic                  ne;
        logic                  nwe;
        logic [CFG_IDX_W-1:0]  nidx;
        logic [CFG_DATA_W-1:0] ndata;
        bit                    settled;
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.edge_seen <= 1'b0;
            i_cfg_we        <= 1'b0;
        end else begin
            nv      = in_ch.valid;
            ne      = in_ch.edge_seen;
            nwe     = 1'b0;
            nidx    = i_cfg_idx;
            ndata   = i_cfg_data;
            settled = !in_ch.valid && pending_results.size() == 0;
            // hold an offered item until it is taken
            if (!in_ch.valid || in_ch.ready) begin
                nv = 1'b0;
                ne = 1'($urandom_range(1));
                if (stim_q.size() != 0) begin
                    job = stim_q[0];
                    case (job.kind)
                        JOB_ITEM: begin
                            if ($urandom_range(99) >= tx_idle_pct) begin
                                nv = 1'b1;
                                ne = job.edge_flag;
                                stim_q.delete(0);
                                items_sent++;
                            end
                        end
                        JOB_CFG: begin
                            if (settled) begin
                                nwe   = 1'b1;
                                nidx  = job.reg_idx;
                                ndata = job.reg_data;
                                apply_register(job.reg_idx, job.reg_data);
                                cfg_writes++;
                                stim_q.delete(0);
                            end
                        end
                        JOB_DRAIN: begin
                            if (settled) stim_q.delete(0);
                        end
                        JOB_MODE: begin
                            tx_idle_pct = job.arg_a;
                            rx_idle_pct = job.arg_b;
                            stim_q.delete(0);
                        end
                        default: begin
                            hold_len = job.arg_a;
                            hold_token++;
                            stim_q.delete(0);
                        end
                    endcase
                end
            end
            in_ch.valid     <= nv;
            in_ch.edge_seen <= ne;
            i_cfg_we        <= nwe;
            i_cfg_idx       <= nidx;
            i_cfg_data      <= ndata;
        end
    end

    // Take output items, with random stalls and requested hold-offs
    always @(posedge i_clk) begin : take_results
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_token != hold_taken) begin
                hold_taken = hold_token;
                hold_left  = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Check output items, predict accepted inputs, watch for a hang
    always @(posedge i_clk) begin : check_results
        t_tick_result want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("output item with nothing pending", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (want.sample_valid) samples_seen++;
                    if (out_ch.drive_level !== want.drive_level)
                        report_mismatch("drive_level", out_ch.drive_level, want.drive_level);
                    if (out_ch.sample_valid !== want.sample_valid)
                        report_mismatch("sample_valid", out_ch.sample_valid,
                                        want.sample_valid);
                    if (out_ch.sample_ticks !== want.sample_ticks)
                        report_mismatch("sample_ticks", out_ch.sample_ticks,
                                        want.sample_ticks);
                    if (out_ch.charge_sum !== want.charge_sum)
                        report_mismatch("charge_sum", out_ch.charge_sum, want.charge_sum);
                end
            end
            if (in_ch.valid && in_ch.ready)
                pending_results.push_back(advance_timer(in_ch.edge_seen));
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("[%0t] no item moved for %0d cycles", $time, STALL_LIMIT);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // Build the stimulus, then wait for the run to drain
    initial begin
        int seg;
        int edge_pct;
        in_ch.valid     = 1'b0;
        in_ch.edge_seen = 1'b0;
        out_ch.ready    = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_rst_n         = 1'b0;

        push_ctrl(JOB_MODE, 31, 62);

        // Reset settings: edge in start and right after start are ignored,
        // then one sample
        push_item(1'b1);
        push_item(1'b1);
        push_item(1'b0);
        push_item(1'b1);

        // Widest timeout: leave discharge quickly, charge long, then sample
        push_ctrl(JOB_DRAIN, 0, 0);
        push_cfg(CFG_TIMEOUT, 16'hFFFF);
        push_cfg(CFG_DISCHARGE, 16'd0);
        repeat (2) push_item(1'b0);
        push_item(1'b0);
        repeat (40) push_item(1'b0);
        push_item(1'b1);

        // Widest discharge delay while ticks keep coming
        push_ctrl(JOB_DRAIN, 0, 0);
        push_cfg(CFG_DISCHARGE, 16'hFFFF);
        repeat (8) push_item(1'($urandom_range(1)));

        // Short timings: sample, edges in discharge, then a timeout
        push_ctrl(JOB_DRAIN, 0, 0);
        push_cfg(CFG_TIMEOUT, 16'd3);
        push_cfg(CFG_DISCHARGE, 16'd2);
        push_cfg(CFG_SAMPLE_COUNT, 16'd2);
        repeat (7) push_item(1'b1);
        push_item(1'b0);
        repeat (9) push_item(1'b0);

        // Shrink the ring under a running write pointer; zero count acts as one
        push_ctrl(JOB_DRAIN, 0, 0);
        push_cfg(CFG_SAMPLE_COUNT, 16'd0);
        repeat (4) push_item(1'b1);

        // Zero timings, counts above the ring depth and the smallest count
        push_ctrl(JOB_DRAIN, 0, 0);
        push_cfg(CFG_TIMEOUT, 16'd0);
        push_cfg(CFG_DISCHARGE, 16'd0);
        push_cfg(CFG_SAMPLE_COUNT, 16'd31);
        repeat (3) push_item(1'b1);
        push_ctrl(JOB_DRAIN, 0, 0);
        push_cfg(CFG_SAMPLE_COUNT, 16'd17);
        repeat (3) push_item(1'b0);
        push_ctrl(JOB_DRAIN, 0, 0);
        push_cfg(CFG_SAMPLE_COUNT, 16'd1);
        repeat (3) push_item(1'b1);

        // Random segments, each under fresh register settings
        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3) push_ctrl(JOB_MODE, 62, 31);
            if (seg == 2 * SEGMENTS / 3) push_ctrl(JOB_MODE, 0, 0);
            push_ctrl(JOB_DRAIN, 0, 0);
            push_cfg(CFG_TIMEOUT, ($urandom_range(7) == 0) ?
                     16'($urandom_range(65535)) : 16'($urandom_range(24)));
            push_cfg(CFG_DISCHARGE, ($urandom_range(7) == 0) ?
                     16'($urandom_range(65535)) : 16'($urandom_range(16)));
            push_cfg(CFG_SAMPLE_COUNT, ($urandom_range(3) == 0) ?
                     16'($urandom_range(65535)) : 16'($urandom_range(17)));
            // stall the receiver long enough to back up the input
            if (seg == SEGMENTS / 3 + 2 || seg == 2 * SEGMENTS / 3 + 2)
                push_ctrl(JOB_HOLD, 300, 0);
            case ($urandom_range(3))
                0:       edge_pct = 3;
                1:       edge_pct = 15;
                2:       edge_pct = 40;
                default: edge_pct = 90;
            endcase
            repeat (SEG_ITEMS) push_item(1'($urandom_range(99) < edge_pct));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || pending_results.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("ran %0d tick items, checked %0d output items with %0d stored charge times",
                 items_sent, results_seen, samples_seen);
        $display("%0d register writes across sender-idle, receiver-idle and full-rate phases",
                 cfg_writes);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
